/* hw/rtl/cppm_pkg.sv */
// Package for the capture period presence monitor: types, constants and register codes.
package cppm_pkg;

  localparam int unsigned STAMP_BITS = 16;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned TICK_BITS  = 16;
  localparam int unsigned REG_BITS   = 16;
  localparam int unsigned CAP_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam int unsigned STAMP_CMP_BITS = (STAMP_BITS > REG_BITS) ? STAMP_BITS : REG_BITS;
  localparam int unsigned COUNT_CMP_BITS = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PERIOD_MIN        = 3'd0,
    REG_PERIOD_MAX        = 3'd1,
    REG_WINDOW_TICKS      = 3'd2,
    REG_MIN_CAPTURES      = 3'd3,
    REG_MIN_GOOD_PERIODS  = 3'd4,
    REG_STATUS_HALF_TICKS = 3'd5,
    REG_LED_TICKS_GOOD    = 3'd6,
    REG_LED_TICKS_BAD     = 3'd7
  } cfg_reg_e;

  localparam logic [REG_BITS-1:0] RST_PERIOD_MIN        = 16'd150;
  localparam logic [REG_BITS-1:0] RST_PERIOD_MAX        = 16'd250;
  localparam logic [REG_BITS-1:0] RST_WINDOW_TICKS      = 16'd100;
  localparam logic [REG_BITS-1:0] RST_MIN_CAPTURES      = 16'd3;
  localparam logic [REG_BITS-1:0] RST_MIN_GOOD_PERIODS  = 16'd2;
  localparam logic [REG_BITS-1:0] RST_STATUS_HALF_TICKS = 16'd5;
  localparam logic [REG_BITS-1:0] RST_LED_TICKS_GOOD    = 16'd500;
  localparam logic [REG_BITS-1:0] RST_LED_TICKS_BAD     = 16'd250;

  typedef enum logic {
    MODE_CAPTURE = 1'b0,
    MODE_TICK    = 1'b1
  } mode_e;

  typedef struct packed {
    logic [REG_BITS-1:0] period_min;
    logic [REG_BITS-1:0] period_max;
    logic [REG_BITS-1:0] window_ticks;
    logic [REG_BITS-1:0] min_captures;
    logic [REG_BITS-1:0] min_good_periods;
    logic [REG_BITS-1:0] status_half_ticks;
    logic [REG_BITS-1:0] led_ticks_good;
    logic [REG_BITS-1:0] led_ticks_bad;
  } cfg_t;

  typedef struct packed {
    logic                mode;
    logic [CAP_BITS-1:0] capture_value;
  } in_req_t;

  typedef struct packed {
    logic status_level;
    logic led_level;
    logic signal_good;
  } out_rsp_t;

endpackage

/* hw/rtl/cppm_cfg.sv */
// Configuration register file of the capture period presence monitor.
module cppm_cfg
  import cppm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [REG_BITS-1:0]     cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PERIOD_MIN:        cfg_d.period_min        = cfg_data_i;
        REG_PERIOD_MAX:        cfg_d.period_max        = cfg_data_i;
        REG_WINDOW_TICKS:      cfg_d.window_ticks      = cfg_data_i;
        REG_MIN_CAPTURES:      cfg_d.min_captures      = cfg_data_i;
        REG_MIN_GOOD_PERIODS:  cfg_d.min_good_periods  = cfg_data_i;
        REG_STATUS_HALF_TICKS: cfg_d.status_half_ticks = cfg_data_i;
        REG_LED_TICKS_GOOD:    cfg_d.led_ticks_good    = cfg_data_i;
        REG_LED_TICKS_BAD:     cfg_d.led_ticks_bad     = cfg_data_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_min        <= RST_PERIOD_MIN;
      cfg_q.period_max        <= RST_PERIOD_MAX;
      cfg_q.window_ticks      <= RST_WINDOW_TICKS;
      cfg_q.min_captures      <= RST_MIN_CAPTURES;
      cfg_q.min_good_periods  <= RST_MIN_GOOD_PERIODS;
      cfg_q.status_half_ticks <= RST_STATUS_HALF_TICKS;
      cfg_q.led_ticks_good    <= RST_LED_TICKS_GOOD;
      cfg_q.led_ticks_bad     <= RST_LED_TICKS_BAD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/capture_period_presence_monitor.sv */
// Top level of the capture period presence monitor.
//
// Usage: each request on the input channel is either a capture timestamp
// (mode 0) or a 1 ms tick (mode 1). Every request yields exactly one
// response carrying the status pin, LED pin and the last window verdict.
// Captures update the period and capture counters; ticks advance the
// window, status and LED timers.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one request per cycle while responses are drained; all
// per-request work (one subtract, a few 16-bit compares and counter
// updates) sits between the request handshake and the response register.
// Stall: in_ready_o stays high while the response register is empty or is
// being drained in the same cycle; a stalled receiver holds the response
// and blocks only further requests.
// Reset: rst_ni clears all counters and flags, sets the LED pin high and
// loads the configuration registers with their defaults. The user writes
// configuration on cfg_we_i/cfg_idx_i/cfg_data_i only while idle; unchecked.
module capture_period_presence_monitor
  import cppm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [REG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_req_t                 in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_rsp_t                out_rsp_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TICK_BITS-1:0]  TICK_MAX  = {TICK_BITS{1'b1}};

  cfg_t cfg;

  cppm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic                  have_prev_q, have_prev_d;
  logic [STAMP_BITS-1:0] prev_q, prev_d;
  logic [COUNT_BITS-1:0] caps_q, caps_d;
  logic [COUNT_BITS-1:0] goods_q, goods_d;
  logic [TICK_BITS-1:0]  win_cnt_q, win_cnt_d;
  logic [TICK_BITS-1:0]  stat_cnt_q, stat_cnt_d;
  logic [TICK_BITS-1:0]  led_cnt_q, led_cnt_d;
  logic                  phase_q, phase_d;
  logic                  good_q, good_d;
  logic                  status_q, status_d;
  logic                  led_q, led_d;
  logic                  out_valid_q;
  out_rsp_t              rsp_q;

  logic                  in_fire;
  logic [STAMP_BITS-1:0] stamp;
  logic [STAMP_BITS-1:0] delta;
  logic                  in_range;
  logic [TICK_BITS-1:0]  win_inc, stat_inc, led_inc;
  logic [REG_BITS-1:0]   led_limit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign stamp    = STAMP_BITS'(in_req_i.capture_value);
  assign delta    = stamp - prev_q;
  assign in_range = (STAMP_CMP_BITS'(delta) >= STAMP_CMP_BITS'(cfg.period_min)) &&
                    (STAMP_CMP_BITS'(delta) <= STAMP_CMP_BITS'(cfg.period_max));

  assign win_inc  = (win_cnt_q == TICK_MAX) ? TICK_MAX : win_cnt_q + 1'b1;
  assign stat_inc = (stat_cnt_q == TICK_MAX) ? TICK_MAX : stat_cnt_q + 1'b1;
  assign led_inc  = (led_cnt_q == TICK_MAX) ? TICK_MAX : led_cnt_q + 1'b1;

  always_comb begin
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    caps_d      = caps_q;
    goods_d     = goods_q;
    win_cnt_d   = win_cnt_q;
    stat_cnt_d  = stat_cnt_q;
    led_cnt_d   = led_cnt_q;
    phase_d     = phase_q;
    good_d      = good_q;
    status_d    = status_q;
    led_d       = led_q;
    led_limit   = cfg.led_ticks_bad;
    if (in_fire) begin
      case (mode_e'(in_req_i.mode))
        MODE_CAPTURE: begin
          if (have_prev_q && in_range && goods_q != COUNT_MAX) begin
            goods_d = goods_q + 1'b1;
          end
          have_prev_d = 1'b1;
          prev_d      = stamp;
          if (caps_q != COUNT_MAX) begin
            caps_d = caps_q + 1'b1;
          end
        end
        MODE_TICK: begin
          win_cnt_d  = win_inc;
          stat_cnt_d = stat_inc;
          led_cnt_d  = led_inc;
          if (win_inc >= cfg.window_ticks) begin
            good_d = (COUNT_CMP_BITS'(caps_q) >= COUNT_CMP_BITS'(cfg.min_captures)) &&
                     (COUNT_CMP_BITS'(goods_q) >= COUNT_CMP_BITS'(cfg.min_good_periods));
            caps_d    = '0;
            goods_d   = '0;
            win_cnt_d = '0;
          end
          if (stat_inc >= cfg.status_half_ticks) begin
            stat_cnt_d = '0;
            phase_d    = !phase_q;
            status_d   = good_d && !phase_q;
          end
          led_limit = good_d ? cfg.led_ticks_good : cfg.led_ticks_bad;
          if (led_inc >= led_limit) begin
            led_cnt_d = '0;
            led_d     = !led_q;
          end
        end
        default: begin
          have_prev_d = have_prev_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      caps_q      <= '0;
      goods_q     <= '0;
      win_cnt_q   <= '0;
      stat_cnt_q  <= '0;
      led_cnt_q   <= '0;
      phase_q     <= 1'b0;
      good_q      <= 1'b0;
      status_q    <= 1'b0;
      led_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      caps_q      <= caps_d;
      goods_q     <= goods_d;
      win_cnt_q   <= win_cnt_d;
      stat_cnt_q  <= stat_cnt_d;
      led_cnt_q   <= led_cnt_d;
      phase_q     <= phase_d;
      good_q      <= good_d;
      status_q    <= status_d;
      led_q       <= led_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q.status_level <= status_d;
      rsp_q.led_level    <= led_d;
      rsp_q.signal_good  <= good_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTH
  a_rsp_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("no response after accepted request");

  a_capture_keeps_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_req_i.mode == MODE_CAPTURE |=>
      led_q == $past(led_q) && status_q == $past(status_q) && good_q == $past(good_q))
    else $error("capture changed a pin or the verdict");

  a_rsp_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> rsp_q.signal_good == good_q && rsp_q.led_level == led_q &&
                rsp_q.status_level == status_q)
    else $error("response does not match updated state");

  a_verdict_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_req_i.mode == MODE_TICK && win_inc >= cfg.window_ticks |=>
      caps_q == '0 && goods_q == '0 && win_cnt_q == '0)
    else $error("window close did not clear counters");

  a_good_le_caps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    goods_q <= caps_q)
    else $error("good period count exceeds capture count");
`endif

endmodule

/* tb/sv/cppm_checker.sv */
// Checker for the capture period presence monitor: tracks config writes, predicts and compares responses.
module cppm_checker
  import cppm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [REG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  in_req_t                 in_req_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  out_rsp_t                out_rsp_i,
  output int unsigned             err_cnt_o,
  output int unsigned             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                  cfg;
  logic                  have_prev;
  logic [STAMP_BITS-1:0] prev_stamp;
  logic [COUNT_BITS-1:0] cap_cnt;
  logic [COUNT_BITS-1:0] good_cnt;
  logic [TICK_BITS-1:0]  win_cnt;
  logic [TICK_BITS-1:0]  stat_cnt;
  logic [TICK_BITS-1:0]  led_cnt;
  logic                  stat_phase;
  logic                  good_flag;
  logic                  stat_pin;
  logic                  led_pin;
  out_rsp_t              rsp_want;
  out_rsp_t              rsp_expected_q[$];

  function automatic out_rsp_t monitor_step(input in_req_t req);
    logic [STAMP_BITS-1:0] stamp;
    logic [STAMP_BITS-1:0] delta;
    logic [REG_BITS-1:0]   led_limit;
    out_rsp_t              rsp;
    if (req.mode == MODE_CAPTURE) begin
      stamp = req.capture_value;
      if (have_prev) begin
        delta = stamp - prev_stamp;
        if (delta >= cfg.period_min && delta <= cfg.period_max && good_cnt != '1) begin
          good_cnt = good_cnt + 1'b1;
        end
      end else begin
        have_prev = 1'b1;
      end
      prev_stamp = stamp;
      if (cap_cnt != '1) begin
        cap_cnt = cap_cnt + 1'b1;
      end
    end else begin
      if (win_cnt != '1) win_cnt = win_cnt + 1'b1;
      if (stat_cnt != '1) stat_cnt = stat_cnt + 1'b1;
      if (led_cnt != '1) led_cnt = led_cnt + 1'b1;
      if (win_cnt >= cfg.window_ticks) begin
        good_flag = (cap_cnt >= cfg.min_captures) && (good_cnt >= cfg.min_good_periods);
        cap_cnt   = '0;
        good_cnt  = '0;
        win_cnt   = '0;
      end
      if (stat_cnt >= cfg.status_half_ticks) begin
        stat_cnt   = '0;
        stat_phase = !stat_phase;
        stat_pin   = good_flag && stat_phase;
      end
      led_limit = good_flag ? cfg.led_ticks_good : cfg.led_ticks_bad;
      if (led_cnt >= led_limit) begin
        led_cnt = '0;
        led_pin = !led_pin;
      end
    end
    rsp.status_level = stat_pin;
    rsp.led_level    = led_pin;
    rsp.signal_good  = good_flag;
    return rsp;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      err_cnt_o = err_cnt_o + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.period_min        = RST_PERIOD_MIN;
      cfg.period_max        = RST_PERIOD_MAX;
      cfg.window_ticks      = RST_WINDOW_TICKS;
      cfg.min_captures      = RST_MIN_CAPTURES;
      cfg.min_good_periods  = RST_MIN_GOOD_PERIODS;
      cfg.status_half_ticks = RST_STATUS_HALF_TICKS;
      cfg.led_ticks_good    = RST_LED_TICKS_GOOD;
      cfg.led_ticks_bad     = RST_LED_TICKS_BAD;
      have_prev  = 1'b0;
      prev_stamp = '0;
      cap_cnt    = '0;
      good_cnt   = '0;
      win_cnt    = '0;
      stat_cnt   = '0;
      led_cnt    = '0;
      stat_phase = 1'b0;
      good_flag  = 1'b0;
      stat_pin   = 1'b0;
      led_pin    = 1'b1;
      rsp_expected_q.delete();
      err_cnt_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_PERIOD_MIN:        cfg.period_min        = cfg_data_i;
          REG_PERIOD_MAX:        cfg.period_max        = cfg_data_i;
          REG_WINDOW_TICKS:      cfg.window_ticks      = cfg_data_i;
          REG_MIN_CAPTURES:      cfg.min_captures      = cfg_data_i;
          REG_MIN_GOOD_PERIODS:  cfg.min_good_periods  = cfg_data_i;
          REG_STATUS_HALF_TICKS: cfg.status_half_ticks = cfg_data_i;
          REG_LED_TICKS_GOOD:    cfg.led_ticks_good    = cfg_data_i;
          REG_LED_TICKS_BAD:     cfg.led_ticks_bad     = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (rsp_expected_q.size() == 0) begin
          $display("%0t: response with no request pending, got %b", $time, out_rsp_i);
          err_cnt_o = err_cnt_o + 1;
        end else begin
          rsp_want = rsp_expected_q.pop_front();
          check_field("status_level", rsp_want.status_level, out_rsp_i.status_level);
          check_field("led_level", rsp_want.led_level, out_rsp_i.led_level);
          check_field("signal_good", rsp_want.signal_good, out_rsp_i.signal_good);
        end
      end
      if (in_valid_i && in_ready_i) begin
        rsp_expected_q.push_back(monitor_step(in_req_i));
      end
    end
    pending_o = rsp_expected_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the capture period presence monitor: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cppm_pkg::*;

  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 118;
  localparam int unsigned WIN_CAPTURES  = 20;
  localparam int unsigned STALL_LIMIT   = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we = 1'b0;
  cfg_reg_e    cfg_idx = REG_PERIOD_MIN;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  out_rsp_t    out_rsp;
  int unsigned err_cnt;
  int unsigned pending;
  bit          gaps_on = 1'b1;
  int unsigned quiet_cycles = 0;
  logic [15:0] stamp = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  capture_period_presence_monitor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  cppm_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  always @(negedge clk_i) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 10);
  end

  // nothing accepted on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** capture_period_presence_monitor: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input in_req_t req);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    in_req_t req;
    req.mode          = MODE_TICK;
    req.capture_value = 16'($urandom);
    send_req(req);
  endtask

  task automatic send_cap(input logic [15:0] value);
    in_req_t req;
    req.mode          = MODE_CAPTURE;
    req.capture_value = value;
    send_req(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
  endtask

  task automatic program_cfg(input cfg_t c);
    drain();
    write_reg(REG_PERIOD_MIN, c.period_min);
    write_reg(REG_PERIOD_MAX, c.period_max);
    write_reg(REG_WINDOW_TICKS, c.window_ticks);
    write_reg(REG_MIN_CAPTURES, c.min_captures);
    write_reg(REG_MIN_GOOD_PERIODS, c.min_good_periods);
    write_reg(REG_STATUS_HALF_TICKS, c.status_half_ticks);
    write_reg(REG_LED_TICKS_GOOD, c.led_ticks_good);
    write_reg(REG_LED_TICKS_BAD, c.led_ticks_bad);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_reg(input int unsigned lo, input int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom_range(hi, lo));
  endfunction

  initial begin
    cfg_t        c;
    int unsigned period;
    int unsigned jitter;
    int unsigned roll;
    logic [15:0] swap;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short window, wrap of the timestamp, deltas on both range limits
    c = '{period_min: 16'd150, period_max: 16'd250, window_ticks: 16'd3, min_captures: 16'd3,
          min_good_periods: 16'd2, status_half_ticks: 16'd1, led_ticks_good: 16'd1,
          led_ticks_bad: 16'd2};
    program_cfg(c);
    send_req('{mode: MODE_TICK, capture_value: 16'hFFFF});
    send_cap(16'hFFFF);
    send_cap(16'h0095);
    send_cap(16'h018F);
    send_cap(16'h0190);
    repeat (4) send_tick();

    // inverted range, zero thresholds
    c = '{period_min: 16'd300, period_max: 16'd200, window_ticks: 16'd0, min_captures: 16'd0,
          min_good_periods: 16'd1, status_half_ticks: 16'd0, led_ticks_good: 16'd0,
          led_ticks_bad: 16'hFFFF};
    program_cfg(c);
    send_cap(16'h0000);
    send_cap(16'h00FA);
    send_tick();
    send_cap(16'h0104);
    send_tick();

    // zero-length delta, then LED threshold dropped below running counter
    c = '{period_min: 16'd0, period_max: 16'd0, window_ticks: 16'hFFFF, min_captures: 16'hFFFF,
          min_good_periods: 16'd0, status_half_ticks: 16'hFFFF, led_ticks_good: 16'hFFFF,
          led_ticks_bad: 16'hFFFF};
    program_cfg(c);
    send_cap(16'h1234);
    send_cap(16'h1234);
    repeat (3) send_tick();
    c.led_ticks_bad = 16'd1;
    c.window_ticks  = 16'd1;
    program_cfg(c);
    repeat (2) send_tick();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      period = $urandom_range(16, 4000);
      jitter = $urandom_range(0, period / 4);
      c.period_min = 16'(period - $urandom_range(0, jitter));
      c.period_max = 16'(period + $urandom_range(0, jitter));
      if ($urandom_range(0, 7) == 0) begin
        swap         = c.period_min;
        c.period_min = c.period_max;
        c.period_max = swap;
      end
      c.window_ticks      = pick_reg(1, 12);
      c.min_captures      = pick_reg(0, 6);
      c.min_good_periods  = pick_reg(0, 4);
      c.status_half_ticks = pick_reg(1, 6);
      c.led_ticks_good    = pick_reg(1, 20);
      c.led_ticks_bad     = pick_reg(1, 20);
      if (ph == RANDOM_PHASES - 1) c = '{default: 16'hFFFF};
      program_cfg(c);
      gaps_on = (ph != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) drain();
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          send_tick();
        end else begin
          if (roll < 87) stamp = stamp + 16'(period - jitter + $urandom_range(0, 2 * jitter));
          else stamp = 16'($urandom);
          send_cap(stamp);
        end
      end
    end

    // a burst of captures in one window, then close the window on them
    gaps_on = 1'b0;
    c = '{period_min: 16'd0, period_max: 16'hFFFF, window_ticks: 16'd0,
          min_captures: 16'hFFFF, min_good_periods: 16'hFFFF, status_half_ticks: 16'd3,
          led_ticks_good: 16'd2, led_ticks_bad: 16'd5};
    program_cfg(c);
    send_tick();
    c.window_ticks = 16'hFFFF;
    program_cfg(c);
    for (int i = 0; i < WIN_CAPTURES; i++) send_cap(16'($urandom));
    c.window_ticks = 16'd1;
    program_cfg(c);
    repeat (2) send_tick();
    gaps_on = 1'b1;

    drain();
    repeat (3) @(negedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("** capture_period_presence_monitor: PASSED **");
    end else begin
      $display("** capture_period_presence_monitor: FAILED **");
    end
    $finish;
  end

endmodule

/* capture_period_presence_monitor.f */
hw/rtl/cppm_pkg.sv
hw/rtl/cppm_cfg.sv
hw/rtl/capture_period_presence_monitor.sv
tb/sv/cppm_checker.sv
tb/sv/tb.sv
